// File: design/msadpcm_pkg.sv
// shared types, constants and lookup tables of the MS ADPCM packet decoder
package msadpcm_pkg;

   // default upper bound on the packet size
   localparam int MAX_PACKET_BYTES_DEF = 8192;

   // configuration register widths and reset values
   localparam int CFG_SIZE_W = 14;
   localparam logic [CFG_SIZE_W-1:0] PKT_SIZE_RESET = 14'd1024;
   localparam int PKT_SIZE_MIN = 16;

   // configuration register indexes
   localparam logic CSR_STEREO   = 1'b0;
   localparam logic CSR_PKT_SIZE = 1'b1;

   // header lengths in bytes
   localparam logic [3:0] HDR_LEN_MONO   = 4'd7;
   localparam logic [3:0] HDR_LEN_STEREO = 4'd14;

   // highest valid predictor index
   localparam logic [7:0] PRED_IDX_MAX = 8'd6;

   // step size clamp bounds
   localparam int STEP_MIN = 16;
   localparam int STEP_MAX = 32767;

   // index of the final header sample in the emission sequence
   localparam logic [1:0] HDR_LAST_K_MONO   = 2'd1;
   localparam logic [1:0] HDR_LAST_K_STEREO = 2'd3;

   // where the current byte falls inside its packet
   typedef enum logic [1:0] {
      CLS_INDEX,
      CLS_FIELD,
      CLS_LAST_HDR,
      CLS_BODY
   } byte_class_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       accept;     // byte taken from the input this cycle
      logic       hdr_write;  // apply a header byte
      logic       adv;        // step the byte position
      logic       mul;        // load the product registers
      logic       upd;        // finish one nibble and emit its sample
      logic       nib_sel;    // 0 high nibble, 1 low nibble
      logic       emit_hdr;   // emit one header sample
      logic [1:0] hdr_k;      // which header sample
      logic       emit_err;   // emit the bad predictor result
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      byte_class_type cls;
      logic           bad_index;
      logic           out_free;
      logic           stereo;
   } sts_type;

   // step adaptation table
   function automatic logic [9:0] adapt_f(input logic [3:0] nib);
      logic [9:0] v;
      case (nib)
         4'd4, 4'd12: v = 10'd307;
         4'd5, 4'd11: v = 10'd409;
         4'd6, 4'd10: v = 10'd512;
         4'd7, 4'd9:  v = 10'd614;
         4'd8:        v = 10'd768;
         default:     v = 10'd230;
      endcase
      return v;
   endfunction

   // first predictor coefficient
   function automatic logic signed [10:0] coef_a_f(input logic [2:0] idx);
      logic signed [10:0] v;
      case (idx)
         3'd0:    v = 11'sd256;
         3'd1:    v = 11'sd512;
         3'd3:    v = 11'sd192;
         3'd4:    v = 11'sd240;
         3'd5:    v = 11'sd460;
         3'd6:    v = 11'sd392;
         default: v = 11'sd0;
      endcase
      return v;
   endfunction

   // second predictor coefficient
   function automatic logic signed [9:0] coef_b_f(input logic [2:0] idx);
      logic signed [9:0] v;
      case (idx)
         3'd1:    v = -10'sd256;
         3'd3:    v = 10'sd64;
         3'd5:    v = -10'sd208;
         3'd6:    v = -10'sd232;
         default: v = 10'sd0;
      endcase
      return v;
   endfunction

endpackage

// File: design/msadpcm_ctrl.sv
// controller state machine of the MS ADPCM packet decoder
module msadpcm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  msadpcm_pkg::sts_type sts,
   output msadpcm_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UPD0 = 3'd1;
   localparam logic [2:0] S_MUL1 = 3'd2;
   localparam logic [2:0] S_UPD1 = 3'd3;
   localparam logic [2:0] S_HOUT = 3'd4;
   localparam logic [2:0] S_ERR  = 3'd5;
   localparam logic [2:0] S_HALT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic [1:0] last_k;

   assign last_k = sts.stereo ? msadpcm_pkg::HDR_LAST_K_STEREO
                              : msadpcm_pkg::HDR_LAST_K_MONO;

   // input is taken while idle, and dropped once halted
   assign req_tready = (state_ff == S_IDLE) || (state_ff == S_HALT);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (sts.cls)
                  msadpcm_pkg::CLS_INDEX: begin
                     if (sts.bad_index) begin
                        state_in = S_ERR;
                     end else begin
                        cmd.hdr_write = 1'b1;
                        cmd.adv       = 1'b1;
                     end
                  end
                  msadpcm_pkg::CLS_FIELD: begin
                     cmd.hdr_write = 1'b1;
                     cmd.adv       = 1'b1;
                  end
                  msadpcm_pkg::CLS_LAST_HDR: begin
                     cmd.hdr_write = 1'b1;
                     cmd.adv       = 1'b1;
                     k_in          = 2'd0;
                     state_in      = S_HOUT;
                  end
                  msadpcm_pkg::CLS_BODY: begin
                     cmd.mul  = 1'b1;
                     state_in = S_UPD0;
                  end
               endcase
            end
         end
         S_UPD0: begin
            if (sts.out_free) begin
               cmd.upd  = 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul     = 1'b1;
            cmd.nib_sel = 1'b1;
            state_in    = S_UPD1;
         end
         S_UPD1: begin
            cmd.nib_sel = 1'b1;
            if (sts.out_free) begin
               cmd.upd  = 1'b1;
               cmd.adv  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_HOUT: begin
            cmd.hdr_k = k_ff;
            if (sts.out_free) begin
               cmd.emit_hdr = 1'b1;
               if (k_ff == last_k) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         S_ERR: begin
            if (sts.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = S_HALT;
            end
         end
         S_HALT: begin
            state_in = S_HALT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

endmodule

// File: design/msadpcm_dp.sv
// datapath of the MS ADPCM packet decoder: position, channel state, nibble math
module msadpcm_dp #(
   parameter int MAX_PACKET_BYTES = msadpcm_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  msadpcm_pkg::cmd_type                cmd,
   output msadpcm_pkg::sts_type                sts,
   input  logic                                csr_wr_en,
   input  logic                                csr_addr,
   input  logic [msadpcm_pkg::CFG_SIZE_W-1:0]  csr_wdata,
   input  logic [7:0]                          req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [15:0]                         rsp_sample,
   output logic                                rsp_channel,
   output logic                                rsp_last,
   output logic                                rsp_error
);

   localparam int POS_W = $clog2(MAX_PACKET_BYTES);
   localparam int SW = ($clog2(MAX_PACKET_BYTES + 1) > msadpcm_pkg::CFG_SIZE_W)
                       ? $clog2(MAX_PACKET_BYTES + 1) : msadpcm_pkg::CFG_SIZE_W;

   localparam logic [1:0] FIELD_STEP   = 2'd0;
   localparam logic [1:0] FIELD_NEWEST = 2'd1;

   // configuration
   logic                                stereo_ff;
   logic [msadpcm_pkg::CFG_SIZE_W-1:0]  size_ff;

   // packet state
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [7:0]                byte_ff;
   logic [7:0]                latch_ff, latch_in;
   logic signed [10:0]        coef_a_ff [2];
   logic signed [10:0]        coef_a_in [2];
   logic signed [9:0]         coef_b_ff [2];
   logic signed [9:0]         coef_b_in [2];
   logic signed [15:0]        step_ff [2];
   logic signed [15:0]        step_in [2];
   logic signed [15:0]        newest_ff [2];
   logic signed [15:0]        newest_in [2];
   logic signed [15:0]        older_ff [2];
   logic signed [15:0]        older_in [2];

   // product registers
   logic signed [26:0]        pa_ff, pa_in;
   logic signed [25:0]        pb_ff, pb_in;
   logic signed [19:0]        ps_ff, ps_in;
   logic signed [26:0]        pd_ff, pd_in;

   // output register
   logic                      rsp_valid_ff;
   logic [15:0]               rsp_sample_ff, rsp_sample_in;
   logic                      rsp_channel_ff, rsp_channel_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_error_ff, rsp_error_in;

   logic [7:0]                byte_in;
   logic [3:0]                hdr_len;
   logic [3:0]                fk;
   logic [1:0]                field;
   logic                      is_index;
   logic                      in_hdr;
   logic                      hdr_last;
   msadpcm_pkg::byte_class_type cls;
   logic                      ch_sel;
   logic [3:0]                nib;
   logic [SW-1:0]             size_w;
   logic [SW-1:0]             eff_size;
   logic [SW-1:0]             pos_inc;
   logic signed [27:0]        sum_w;
   logic signed [19:0]        q_w;
   logic signed [20:0]        pred_w;
   logic signed [15:0]        pred_sat;
   logic signed [18:0]        dq_w;
   logic signed [15:0]        step_new;
   logic [1:0]                last_k;
   logic                      emit;

   // byte under work: straight from the input on the accept cycle
   assign byte_in = cmd.accept ? req_data : byte_ff;

   // position decode
   assign hdr_len  = stereo_ff ? msadpcm_pkg::HDR_LEN_STEREO : msadpcm_pkg::HDR_LEN_MONO;
   assign is_index = (pos_ff == '0) || (stereo_ff && (pos_ff == POS_W'(1)));
   assign in_hdr   = pos_ff < POS_W'(hdr_len);
   assign hdr_last = pos_ff == POS_W'(hdr_len - 4'd1);
   assign fk       = pos_ff[3:0] - 4'd1 - {3'b000, stereo_ff};
   assign field    = stereo_ff ? fk[3:2] : fk[2:1];

   always_comb begin
      if (is_index) begin
         cls = msadpcm_pkg::CLS_INDEX;
      end else if (hdr_last) begin
         cls = msadpcm_pkg::CLS_LAST_HDR;
      end else if (in_hdr) begin
         cls = msadpcm_pkg::CLS_FIELD;
      end else begin
         cls = msadpcm_pkg::CLS_BODY;
      end
   end

   // single channel select for every state access
   always_comb begin
      if (cmd.emit_hdr) begin
         ch_sel = stereo_ff & cmd.hdr_k[0];
      end else if (cmd.mul || cmd.upd) begin
         ch_sel = stereo_ff & cmd.nib_sel;
      end else if (is_index) begin
         ch_sel = pos_ff[0];
      end else begin
         ch_sel = stereo_ff & fk[1];
      end
   end

   // the index check is only looked at on the accept cycle, so it reads the input directly
   assign sts.cls       = cls;
   assign sts.bad_index = req_data > msadpcm_pkg::PRED_IDX_MAX;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign sts.stereo    = stereo_ff;

   // products for one nibble
   assign nib   = cmd.nib_sel ? byte_in[3:0] : byte_in[7:4];
   assign pa_in = newest_ff[ch_sel] * coef_a_ff[ch_sel];
   assign pb_in = older_ff[ch_sel] * coef_b_ff[ch_sel];
   assign ps_in = $signed(nib) * step_ff[ch_sel];
   assign pd_in = $signed({1'b0, msadpcm_pkg::adapt_f(nib)}) * step_ff[ch_sel];

   // prediction, divide toward zero, add the scaled nibble, saturate
   assign sum_w  = 28'(pa_ff) + 28'(pb_ff);
   assign q_w    = $signed(sum_w[27:8])
                   + ((sum_w[27] && (sum_w[7:0] != 8'd0)) ? 20'sd1 : 20'sd0);
   assign pred_w = 21'(q_w) + 21'(ps_ff);

   always_comb begin
      if (pred_w > 21'sd32767) begin
         pred_sat = 16'sd32767;
      end else if (pred_w < -21'sd32768) begin
         pred_sat = -16'sd32768;
      end else begin
         pred_sat = pred_w[15:0];
      end
   end

   // step adaptation, divide toward zero, clamp
   assign dq_w = $signed(pd_ff[26:8])
                 + ((pd_ff[26] && (pd_ff[7:0] != 8'd0)) ? 19'sd1 : 19'sd0);

   always_comb begin
      if (dq_w < 19'(msadpcm_pkg::STEP_MIN)) begin
         step_new = 16'(msadpcm_pkg::STEP_MIN);
      end else if (dq_w > 19'(msadpcm_pkg::STEP_MAX)) begin
         step_new = 16'(msadpcm_pkg::STEP_MAX);
      end else begin
         step_new = dq_w[15:0];
      end
   end

   // effective packet size and position wrap
   assign size_w  = SW'(size_ff);
   assign pos_inc = SW'(pos_ff) + SW'(1);

   always_comb begin
      if (size_w < SW'(msadpcm_pkg::PKT_SIZE_MIN)) begin
         eff_size = SW'(msadpcm_pkg::PKT_SIZE_MIN);
      end else if (size_w > SW'(MAX_PACKET_BYTES)) begin
         eff_size = SW'(MAX_PACKET_BYTES);
      end else begin
         eff_size = size_w;
      end
   end

   // channel state updates
   always_comb begin
      coef_a_in = coef_a_ff;
      coef_b_in = coef_b_ff;
      step_in   = step_ff;
      newest_in = newest_ff;
      older_in  = older_ff;
      latch_in  = latch_ff;
      pos_in    = pos_ff;
      if (cmd.hdr_write) begin
         if (is_index) begin
            coef_a_in[ch_sel] = msadpcm_pkg::coef_a_f(byte_in[2:0]);
            coef_b_in[ch_sel] = msadpcm_pkg::coef_b_f(byte_in[2:0]);
         end else if (!fk[0]) begin
            latch_in = byte_in;
         end else begin
            case (field)
               FIELD_STEP:   step_in[ch_sel]   = {byte_in, latch_ff};
               FIELD_NEWEST: newest_in[ch_sel] = {byte_in, latch_ff};
               default:      older_in[ch_sel]  = {byte_in, latch_ff};
            endcase
         end
      end
      if (cmd.upd) begin
         older_in[ch_sel]  = newest_ff[ch_sel];
         newest_in[ch_sel] = pred_sat;
         step_in[ch_sel]   = step_new;
      end
      if (cmd.adv) begin
         pos_in = (pos_inc >= eff_size) ? '0 : pos_inc[POS_W-1:0];
      end
   end

   // result selection
   assign last_k = stereo_ff ? msadpcm_pkg::HDR_LAST_K_STEREO : msadpcm_pkg::HDR_LAST_K_MONO;
   assign emit   = cmd.upd || cmd.emit_hdr || cmd.emit_err;

   always_comb begin
      rsp_sample_in  = 16'd0;
      rsp_channel_in = ch_sel;
      rsp_last_in    = 1'b1;
      rsp_error_in   = 1'b0;
      if (cmd.upd) begin
         rsp_sample_in = pred_sat;
         rsp_last_in   = cmd.nib_sel;
      end else if (cmd.emit_hdr) begin
         if (stereo_ff ? cmd.hdr_k[1] : cmd.hdr_k[0]) begin
            rsp_sample_in = newest_ff[ch_sel];
         end else begin
            rsp_sample_in = older_ff[ch_sel];
         end
         rsp_last_in = cmd.hdr_k == last_k;
      end else begin
         rsp_error_in = 1'b1;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff <= 1'b0;
         size_ff   <= msadpcm_pkg::PKT_SIZE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            msadpcm_pkg::CSR_STEREO:   stereo_ff <= csr_wdata[0];
            msadpcm_pkg::CSR_PKT_SIZE: size_ff   <= csr_wdata;
         endcase
      end
   end

   // packet and channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         latch_ff  <= 8'd0;
         coef_a_ff <= '{default: '0};
         coef_b_ff <= '{default: '0};
         step_ff   <= '{default: '0};
         newest_ff <= '{default: '0};
         older_ff  <= '{default: '0};
      end else begin
         pos_ff    <= pos_in;
         latch_ff  <= latch_in;
         coef_a_ff <= coef_a_in;
         coef_b_ff <= coef_b_in;
         step_ff   <= step_in;
         newest_ff <= newest_in;
         older_ff  <= older_in;
      end
   end

   // byte and product registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff <= req_data;
      end
      if (cmd.mul) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         ps_ff <= ps_in;
         pd_ff <= pd_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_sample_ff  <= rsp_sample_in;
         rsp_channel_ff <= rsp_channel_in;
         rsp_last_ff    <= rsp_last_in;
         rsp_error_ff   <= rsp_error_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_sample  = rsp_sample_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_error   = rsp_error_ff;

endmodule

// File: design/ms_adpcm_packet_decoder.sv
// top level of the MS ADPCM packet decoder
//
//  channel  dir  handshake             payload
//  req_     in   req_tvalid/tready     tdata[7:0] data_byte
//  rsp_     out  rsp_tvalid/tready     tdata[15:0] sample, tuser {error, channel}, tlast
//  csr_     in   csr_wr_en             csr_addr register index, csr_wdata value
//
// a header byte is applied as it is taken; the last header byte then puts out two (mono)
// or four (stereo) samples, one per cycle while the output register is free
// a body byte goes through two passes of multiply then update, one per nibble,
// each update waiting for the single output register to be free
// reset is synchronous, clears the position and channel state and resets the configuration
// a bad predictor index gives one error item, then input items are taken and dropped
module ms_adpcm_packet_decoder #(
   parameter int MAX_PACKET_BYTES = msadpcm_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] data_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,   // [15:0] sample
   output logic [1:0]                         rsp_tuser,   // [0] channel, [1] error
   output logic                               rsp_tlast,
   input  logic                               csr_wr_en,
   input  logic                               csr_addr,
   input  logic [msadpcm_pkg::CFG_SIZE_W-1:0] csr_wdata
);

   msadpcm_pkg::cmd_type cmd;
   msadpcm_pkg::sts_type sts;
   logic                 rsp_channel;
   logic                 rsp_error;

   // sequencing
   msadpcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // state and arithmetic
   msadpcm_dp #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_data    (req_tdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_sample  (rsp_tdata),
      .rsp_channel (rsp_channel),
      .rsp_last    (rsp_tlast),
      .rsp_error   (rsp_error)
   );

   assign rsp_tuser = {rsp_error, rsp_channel};

   // at most one source loads the output register
   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.upd, cmd.emit_hdr, cmd.emit_err}))
      else $error("two result sources in one cycle");

   // a result is only loaded into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.upd || cmd.emit_hdr || cmd.emit_err) |-> sts.out_free)
      else $error("output register overwritten");

   // an error item is a lone, zero, final item
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tlast && (rsp_tdata == 16'd0)))
      else $error("malformed error item");

   // nothing follows a delivered error item
   a_err_halt: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tuser[1]) |=> !rsp_tvalid)
      else $error("result after halt");

endmodule

// File: tb/testbench.sv
// testbench of the ms adpcm packet decoder: directed and random streams, local decoder
module testbench;
   import msadpcm_pkg::*;

   localparam int PKT_MAX       = MAX_PACKET_BYTES_DEF;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int REPORT_MAX    = 50;

   // one decoded sample as it leaves the block
   typedef struct {
      logic signed [15:0] sample;
      logic               channel;
      logic               last;
      logic               error;
   } pcm_item_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] data_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;   // [15:0] sample
   logic [1:0]            rsp_tuser;   // [0] channel, [1] error
   logic                  rsp_tlast;
   logic                  csr_wr_en;
   logic                  csr_addr;
   logic [CFG_SIZE_W-1:0] csr_wdata;

   // local copy of configuration and decoder state
   logic                  cfg_stereo;
   logic [CFG_SIZE_W-1:0] cfg_size;
   int unsigned           pkt_pos;
   logic signed [10:0]    coef_a [2];
   logic signed [9:0]     coef_b [2];
   logic signed [15:0]    step [2];
   logic signed [15:0]    newest [2];
   logic signed [15:0]    older [2];
   logic [7:0]            low_latch;
   bit                    halted;

   pcm_item_type          expected_samples [$];
   pcm_item_type          want;
   logic [7:0]            script [$];
   int                    mismatches = 0;
   int                    cycles = 0;
   int                    idle_pct;
   int                    stall_pct;

   ms_adpcm_packet_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run length guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // compare each sample leaving the block with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: expected nothing, got sample %0d ch %0d last %0d err %0d",
                        $time, $signed(rsp_tdata), rsp_tuser[0], rsp_tlast, rsp_tuser[1]);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_tdata !== want.sample || rsp_tuser[0] !== want.channel ||
                rsp_tlast !== want.last || rsp_tuser[1] !== want.error) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: expected sample %0d ch %0d last %0d err %0d, got %0d %0d %0d %0d",
                           $time, want.sample, want.channel, want.last, want.error,
                           $signed(rsp_tdata), rsp_tuser[0], rsp_tlast, rsp_tuser[1]);
            end
         end
      end
   end

   // step adaptation factor per nibble
   function automatic int step_scale(input logic [3:0] nib);
      case (nib)
         4'h4, 4'hC: return 307;
         4'h5, 4'hB: return 409;
         4'h6, 4'hA: return 512;
         4'h7, 4'h9: return 614;
         4'h8:       return 768;
         default:    return 230;
      endcase
   endfunction

   // predictor coefficients per index
   function automatic int first_coef(input logic [7:0] idx);
      case (idx)
         8'd0: return 256;
         8'd1: return 512;
         8'd3: return 192;
         8'd4: return 240;
         8'd5: return 460;
         8'd6: return 392;
         default: return 0;
      endcase
   endfunction

   function automatic int second_coef(input logic [7:0] idx);
      case (idx)
         8'd1: return -256;
         8'd3: return 64;
         8'd5: return -208;
         8'd6: return -232;
         default: return 0;
      endcase
   endfunction

   function automatic void push_sample(input logic [15:0] s, input logic ch,
                                       input logic last, input logic err);
      pcm_item_type r;
      r.sample  = s;
      r.channel = ch;
      r.last    = last;
      r.error   = err;
      expected_samples.push_back(r);
   endfunction

   // one nibble through prediction, saturation and step adaptation
   function automatic logic [15:0] decode_nibble(input int ch, input logic [3:0] nib);
      int pred;
      int sn;
      int d;
      pred = (int'(newest[ch]) * int'(coef_a[ch]) + int'(older[ch]) * int'(coef_b[ch])) / 256;
      sn = nib[3] ? int'(nib) - 16 : int'(nib);
      pred += sn * int'(step[ch]);
      if (pred > 32767) pred = 32767;
      if (pred < -32768) pred = -32768;
      older[ch] = newest[ch];
      newest[ch] = pred[15:0];
      d = (step_scale(nib) * int'(step[ch])) / 256;
      if (d < 16) d = 16;
      if (d > 32767) d = 32767;
      step[ch] = d[15:0];
      return pred[15:0];
   endfunction

   // expected samples caused by one accepted byte
   function automatic void predict_samples(input logic [7:0] b);
      int unsigned size;
      int unsigned st;
      int unsigned hdr_len;
      int unsigned k;
      int unsigned word;
      int unsigned field;
      int          ch;
      logic [15:0] s0;
      logic [15:0] s1;
      if (halted) return;
      size = 32'(cfg_size);
      if (size < PKT_SIZE_MIN) size = PKT_SIZE_MIN;
      if (size > PKT_MAX) size = PKT_MAX;
      st = 32'(cfg_stereo);
      hdr_len = st ? 32'(HDR_LEN_STEREO) : 32'(HDR_LEN_MONO);
      if (pkt_pos <= st) begin
         // predictor index
         ch = pkt_pos & 1;
         if (b > PRED_IDX_MAX) begin
            halted = 1'b1;
            push_sample(16'd0, ch[0], 1'b1, 1'b1);
            return;
         end
         coef_a[ch] = 11'(first_coef(b));
         coef_b[ch] = 10'(second_coef(b));
      end else if (pkt_pos < hdr_len) begin
         // little-endian header words, channels interleaved
         k = pkt_pos - (1 + st);
         word = k >> 1;
         field = word >> st;
         ch = word & st;
         if (!k[0]) begin
            low_latch = b;
         end else if (field == 0) begin
            step[ch] = {b, low_latch};
         end else if (field == 1) begin
            newest[ch] = {b, low_latch};
         end else begin
            older[ch] = {b, low_latch};
         end
         if (pkt_pos == hdr_len - 1) begin
            push_sample(older[0], 1'b0, 1'b0, 1'b0);
            if (st) push_sample(older[1], 1'b1, 1'b0, 1'b0);
            push_sample(newest[0], 1'b0, !st, 1'b0);
            if (st) push_sample(newest[1], 1'b1, 1'b1, 1'b0);
         end
      end else begin
         // body byte, high nibble first
         s0 = decode_nibble(0, b[7:4]);
         s1 = decode_nibble(st, b[3:0]);
         push_sample(s0, 1'b0, 1'b0, 1'b0);
         push_sample(s1, st[0], 1'b1, 1'b0);
      end
      pkt_pos++;
      if (pkt_pos >= size) pkt_pos = 0;
   endfunction

   // send one item, with random sender gaps
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      predict_samples(b);
   endtask

   // random bytes, with valid predictor indexes where an index is due
   task automatic send_stream(input int n);
      for (int i = 0; i < n; i++) begin
         if (pkt_pos <= cfg_stereo)
            send_byte(8'($urandom_range(PRED_IDX_MAX)));
         else
            send_byte(8'($urandom_range(255)));
      end
   endtask

   // drain all samples, then let the block go quiet
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both registers, only while idle
   task automatic set_config(input logic stereo, input logic [CFG_SIZE_W-1:0] size);
      csr_wr_en <= 1'b1;
      csr_addr <= CSR_STEREO;
      csr_wdata <= CFG_SIZE_W'(stereo);
      @(posedge clock);
      cfg_stereo = stereo;
      csr_addr <= CSR_PKT_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      cfg_size = size;
      csr_wr_en <= 1'b0;
   endtask

   // mono packet with saturating samples, full step and size below the minimum
   task automatic test_mono_extremes();
      wait_idle();
      set_config(1'b0, 14'd3);
      script = '{8'h06, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h77,
                 8'h88, 8'h0F, 8'hF0, 8'h00, 8'hFF, 8'h80, 8'h08, 8'h5A};
      foreach (script[i]) send_byte(script[i]);
   endtask

   // stereo header with a negative header step and extreme samples
   task automatic test_stereo_header();
      wait_idle();
      set_config(1'b1, CFG_SIZE_W'(PKT_SIZE_MIN));
      script = '{8'h00, 8'h05, 8'h00, 8'h80, 8'h10, 8'h00, 8'hFF, 8'h7F,
                 8'h00, 8'h80, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'h7F, 8'hF8};
      foreach (script[i]) send_byte(script[i]);
   endtask

   // size above the maximum, then shrunk below the current position
   task automatic test_size_change();
      wait_idle();
      set_config(1'b0, 14'd9000);
      send_stream(24);
      wait_idle();
      set_config(1'b1, CFG_SIZE_W'(PKT_SIZE_MIN));
      send_stream(20);
   endtask

   // random packets under one idling pattern
   task automatic test_random_phase(input int sender_idle, input int receiver_stall,
                                    input int n_bytes);
      int                    sent;
      int                    n;
      logic [CFG_SIZE_W-1:0] size;
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      sent = 0;
      while (sent < n_bytes) begin
         if (sent == 0 || $urandom_range(2) == 0) begin
            wait_idle();
            case ($urandom_range(9))
               0:       size = CFG_SIZE_W'(PKT_SIZE_MIN);
               1:       size = CFG_SIZE_W'(PKT_MAX);
               2:       size = CFG_SIZE_W'($urandom_range(PKT_SIZE_MIN - 1));
               3:       size = CFG_SIZE_W'($urandom_range(16383, PKT_MAX + 1));
               default: size = CFG_SIZE_W'($urandom_range(64, PKT_SIZE_MIN));
            endcase
            set_config(1'($urandom_range(1)), size);
         end
         n = $urandom_range(60, 20);
         if (n > n_bytes - sent) n = n_bytes - sent;
         send_stream(n);
         sent += n;
      end
   endtask

   // bad index on the right channel halts the block; later items are dropped
   task automatic test_bad_index();
      wait_idle();
      set_config(1'b1, CFG_SIZE_W'(PKT_SIZE_MIN));
      while (pkt_pos != 1) send_stream(1);
      send_byte(8'($urandom_range(255, PRED_IDX_MAX + 1)));
      send_stream(12);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      csr_wr_en = 1'b0;
      csr_addr = CSR_STEREO;
      csr_wdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      cfg_stereo = 1'b0;
      cfg_size = PKT_SIZE_RESET;
      pkt_pos = 0;
      low_latch = 8'd0;
      halted = 1'b0;
      for (int c = 0; c < 2; c++) begin
         coef_a[c] = '0;
         coef_b[c] = '0;
         step[c] = '0;
         newest[c] = '0;
         older[c] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_mono_extremes();
      test_stereo_header();
      test_size_change();
      test_random_phase(0, 0, 80);
      test_random_phase(58, 0, 80);
      test_random_phase(0, 58, 80);
      test_random_phase(32, 32, 80);
      test_bad_index();
      wait_idle();

      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
